// File: design/atilt_pkg.sv
package atilt_pkg;

  localparam int ACC_W  = 16;
  localparam int LIN_W  = ACC_W + 8;
  localparam int SUM_W  = 2 * ACC_W;
  localparam int ROOT_W = 24;
  localparam int REM_W  = ROOT_W + 3;
  localparam int CW     = 27;
  localparam int ZW     = 26;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int OUT_W  = 18;

  localparam int DEG180    = 180 * 65536;
  localparam int CENTI     = 100;
  localparam int OUT_LIMIT = 100000;

  localparam logic [1:0] MODE_X = 2'd0;
  localparam logic [1:0] MODE_Y = 2'd1;

  localparam logic [1:0] REG_AXIS_MODE    = 2'd0;
  localparam logic [1:0] REG_ANGLE_GAIN   = 2'd1;
  localparam logic [1:0] REG_ANGLE_OFFSET = 2'd2;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  localparam int ATAN_TAB [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
  } in_payload_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] angle_centideg;
    logic                    clipped;
  } out_payload_t;

  // operand context carried alongside the square root
  typedef struct packed {
    logic signed [LIN_W-1:0] lin;
    logic                    sel_z;
    logic                    neg;
  } sq_ctx_t;

endpackage

// File: design/atilt_sqrt.sv
module atilt_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [atilt_pkg::SUM_W-1:0] in_sum,
  input  atilt_pkg::sq_ctx_t         in_ctx,
  output logic                       out_vld,
  output logic [atilt_pkg::ROOT_W-1:0] out_root,
  output atilt_pkg::sq_ctx_t         out_ctx
);
  import atilt_pkg::*;

  // floor(sqrt(sum * 2^16)), one result bit per stage

  logic [ROOT_W-1:0] vld_r;
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SUM_W-1:0]  sum_r  [ROOT_W];
  sq_ctx_t           ctx_r  [ROOT_W];

  logic [REM_W-1:0]  p_rem    [ROOT_W];
  logic [ROOT_W-1:0] p_root   [ROOT_W];
  logic [SUM_W-1:0]  p_sum    [ROOT_W];
  sq_ctx_t           p_ctx    [ROOT_W];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [SUM_W-1:0]  sum_nxt  [ROOT_W];

  always_comb begin
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    p_rem[0]  = '0;
    p_root[0] = '0;
    p_sum[0]  = in_sum;
    p_ctx[0]  = in_ctx;
    for (int k = 1; k < ROOT_W; k++) begin
      p_rem[k]  = rem_r[k-1];
      p_root[k] = root_r[k-1];
      p_sum[k]  = sum_r[k-1];
      p_ctx[k]  = ctx_r[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      rem_sh = {p_rem[k][REM_W-3:0], p_sum[k][SUM_W-1:SUM_W-2]};
      trial  = REM_W'({p_root[k], 2'b01});
      if (rem_sh >= trial) begin
        rem_nxt[k]  = rem_sh - trial;
        root_nxt[k] = {p_root[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = rem_sh;
        root_nxt[k] = {p_root[k][ROOT_W-2:0], 1'b0};
      end
      sum_nxt[k] = {p_sum[k][SUM_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ROOT_W-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        sum_r[k]  <= sum_nxt[k];
        ctx_r[k]  <= p_ctx[k];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_ctx  = ctx_r[ROOT_W-1];

endmodule

// File: design/atilt_cordic.sv
module atilt_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [atilt_pkg::CW-1:0] in_num,
  input  logic signed [atilt_pkg::CW-1:0] in_den,
  input  logic                           in_neg,
  output logic                           out_vld,
  output logic signed [atilt_pkg::ZW-1:0] out_ang,
  output logic                           out_neg
);
  import atilt_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  // index 0 holds the folded vector, index k+1 the result of iteration k
  logic [NSTEPS:0]        vld_r;
  logic signed [CW-1:0]   x_r    [NSTEPS+1];
  logic signed [CW-1:0]   y_r    [NSTEPS+1];
  logic signed [ZW-1:0]   z_r    [NSTEPS+1];
  logic                   zero_r [NSTEPS+1];
  logic                   neg_r  [NSTEPS+1];

  logic signed [CW-1:0]   x0, y0;
  logic signed [ZW-1:0]   z0;
  logic signed [CW-1:0]   x_nxt [NSTEPS];
  logic signed [CW-1:0]   y_nxt [NSTEPS];
  logic signed [ZW-1:0]   z_nxt [NSTEPS];

  // left half plane: negate and start from +-180 degrees
  always_comb begin
    if (in_den[CW-1]) begin
      x0 = -in_den;
      y0 = -in_num;
      z0 = in_num[CW-1] ? -ZW'(DEG180) : ZW'(DEG180);
    end else begin
      x0 = in_den;
      y0 = in_num;
      z0 = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < NSTEPS; k++) begin
      if (!y_r[k][CW-1]) begin
        x_nxt[k] = x_r[k] + (y_r[k] >>> k);
        y_nxt[k] = y_r[k] - (x_r[k] >>> k);
        z_nxt[k] = z_r[k] + ZW'(ATAN_TAB[k]);
      end else begin
        x_nxt[k] = x_r[k] - (y_r[k] >>> k);
        y_nxt[k] = y_r[k] + (x_r[k] >>> k);
        z_nxt[k] = z_r[k] - ZW'(ATAN_TAB[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTEPS-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0;
      y_r[0]    <= y0;
      z_r[0]    <= z0;
      zero_r[0] <= (in_num == '0) && (in_den == '0);
      neg_r[0]  <= in_neg;
      for (int k = 0; k < NSTEPS; k++) begin
        x_r[k+1]    <= x_nxt[k];
        y_r[k+1]    <= y_nxt[k];
        z_r[k+1]    <= z_nxt[k];
        zero_r[k+1] <= zero_r[k];
        neg_r[k+1]  <= neg_r[k];
      end
    end
  end

  assign out_vld = vld_r[NSTEPS];
  assign out_ang = zero_r[NSTEPS] ? '0 : z_r[NSTEPS];
  assign out_neg = neg_r[NSTEPS];

endmodule

// File: design/accel_tilt_angle.sv
// Tilt angle of one three-axis accelerometer sample, in centidegrees.
// Input channel: in_valid / in_stall / in_data (accel_x, accel_y, accel_z).
// Result channel: out_valid / out_stall / out_data (angle_centideg, clipped),
// one result per input, in input order.
// Configuration: APB-style port, registers at 0x0 axis_mode, 0x4 angle_gain,
// 0x8 angle_offset; pready is always high. Write only while the block is idle.
// Pipeline from input transfer to out_valid: squares and sum, the
// bit-per-stage square root, the CORDIC, scaling and rounding, and the
// output register.
// Throughput: one sample per cycle while the receiver takes results.
// Reset: pipeline empty, registers at axis_mode 1, angle_gain 18514,
// angle_offset 0. No memory to clear; a transfer is taken right after reset.
// Receiver stall: the result holds in the output register and one more goes
// to a skid register; with the skid register full the whole pipeline holds
// and in_stall is high, so nothing is lost or repeated.
module accel_tilt_angle #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  atilt_pkg::in_payload_t        in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output atilt_pkg::out_payload_t       out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [atilt_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [atilt_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [atilt_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                          cfg_pready
);
  import atilt_pkg::*;

  localparam int P1W = 32;
  localparam int P2W = P1W + 17;
  localparam int DW  = P2W + 1;
  localparam int QW  = DW - 30;

  // configuration
  logic [1:0]         axis_mode_r;
  logic [15:0]        angle_gain_r;
  logic signed [16:0] angle_offset_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_mode_r    <= 2'd1;
      angle_gain_r   <= 16'd18514;
      angle_offset_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_AXIS_MODE:    axis_mode_r    <= cfg_pwdata[1:0];
        REG_ANGLE_GAIN:   angle_gain_r   <= cfg_pwdata[15:0];
        REG_ANGLE_OFFSET: angle_offset_r <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_AXIS_MODE:    cfg_prdata = {30'b0, axis_mode_r};
      REG_ANGLE_GAIN:   cfg_prdata = {16'b0, angle_gain_r};
      REG_ANGLE_OFFSET: cfg_prdata = {{15{angle_offset_r[16]}}, angle_offset_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // pipeline enable: holds only when the skid register is occupied
  logic skid_vld_r;
  logic en;

  assign en       = !skid_vld_r;
  assign in_stall = skid_vld_r;

  // stage 1: operand selection and squares
  logic signed [ACC_W-1:0] sel_a, sel_b, sel_l;
  sq_ctx_t                 ctx1_nxt, ctx1_r, ctx2_r;
  logic signed [SUM_W-1:0] sqa_nxt, sqb_nxt, sqa_r, sqb_r;
  logic [SUM_W-1:0]        sum_r;
  logic                    s1_vld_r, s2_vld_r;

  always_comb begin
    ctx1_nxt = '0;
    if (axis_mode_r == MODE_X) begin
      sel_a = in_data.accel_y;
      sel_b = in_data.accel_z;
      sel_l = in_data.accel_x;
    end else if (axis_mode_r == MODE_Y) begin
      sel_a = in_data.accel_x;
      sel_b = in_data.accel_z;
      sel_l = in_data.accel_y;
      ctx1_nxt.neg = 1'b1;
    end else begin
      sel_a = in_data.accel_x;
      sel_b = in_data.accel_y;
      sel_l = in_data.accel_z;
      ctx1_nxt.sel_z = 1'b1;
    end
    ctx1_nxt.lin = {sel_l, 8'b0};
    sqa_nxt = SUM_W'(sel_a) * SUM_W'(sel_a);
    sqb_nxt = SUM_W'(sel_b) * SUM_W'(sel_b);
  end

  // stage 2: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      sqa_r  <= sqa_nxt;
      sqb_r  <= sqb_nxt;
      ctx1_r <= ctx1_nxt;
      sum_r  <= unsigned'(sqa_r) + unsigned'(sqb_r);
      ctx2_r <= ctx1_r;
    end
  end

  // square root
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  sq_ctx_t           sq_ctx;

  atilt_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s2_vld_r),
    .in_sum   (sum_r),
    .in_ctx   (ctx2_r),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_ctx  (sq_ctx)
  );

  // atan2 operands
  logic signed [CW-1:0] root_s, lin_s, cd_num, cd_den;

  assign root_s = CW'(signed'({1'b0, sq_root}));
  assign lin_s  = CW'($signed(sq_ctx.lin));
  assign cd_num = sq_ctx.sel_z ? root_s : lin_s;
  assign cd_den = sq_ctx.sel_z ? lin_s  : root_s;

  logic                 cd_vld, cd_neg;
  logic signed [ZW-1:0] cd_ang;

  atilt_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (sq_vld),
    .in_num  (cd_num),
    .in_den  (cd_den),
    .in_neg  (sq_ctx.neg),
    .out_vld (cd_vld),
    .out_ang (cd_ang),
    .out_neg (cd_neg)
  );

  // scaling: D = A*100*gain - offset*2^30, round half away from zero
  logic signed [ZW-1:0]  a1_r;
  logic signed [P1W-1:0] p1_r;
  logic signed [P2W-1:0] p2_r;
  logic signed [DW-1:0]  d_r;
  logic [DW-1:0]         magd_r;
  logic                  negd_r;
  logic [QW-1:0]         q_r;
  logic                  negq_r;
  logic                  t1_vld_r, t2_vld_r, t3_vld_r, t4_vld_r, t5_vld_r, t6_vld_r;
  logic signed [16:0]    gain_s;
  logic [DW-1:0]         rnd_sum;

  assign gain_s  = signed'({1'b0, angle_gain_r});
  assign rnd_sum = magd_r + (DW'(1) << 29);

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= cd_neg ? -cd_ang : cd_ang;
      p1_r   <= P1W'(a1_r) * P1W'(CENTI);
      p2_r   <= P2W'(p1_r) * P2W'(gain_s);
      d_r    <= DW'(p2_r) - (DW'(angle_offset_r) <<< 30);
      negd_r <= d_r[DW-1];
      magd_r <= d_r[DW-1] ? unsigned'(-d_r) : unsigned'(d_r);
      negq_r <= negd_r;
      q_r    <= rnd_sum[DW-1:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      t1_vld_r <= 1'b0;
      t2_vld_r <= 1'b0;
      t3_vld_r <= 1'b0;
      t4_vld_r <= 1'b0;
      t5_vld_r <= 1'b0;
      t6_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      t1_vld_r <= cd_vld;
      t2_vld_r <= t1_vld_r;
      t3_vld_r <= t2_vld_r;
      t4_vld_r <= t3_vld_r;
      t5_vld_r <= t4_vld_r;
      t6_vld_r <= t5_vld_r;
    end
  end

  // saturation and sign
  out_payload_t      fin;
  logic [OUT_W-1:0]  fin_mag;

  always_comb begin
    fin.clipped        = q_r > QW'(OUT_LIMIT);
    fin_mag            = fin.clipped ? OUT_W'(OUT_LIMIT) : OUT_W'(q_r);
    fin.angle_centideg = negq_r ? -signed'(fin_mag) : signed'(fin_mag);
  end

  // output register and skid register
  logic         out_vld_r, out_vld_nxt, skid_vld_nxt;
  out_payload_t out_data_r, out_data_nxt, skid_r, skid_nxt;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    out_data_nxt = out_data_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (!out_stall) begin
        out_data_nxt = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (t6_vld_r) begin
      if (!out_vld_r || !out_stall) begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = fin;
      end else begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = fin;
      end
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_r     <= skid_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// File: dv/accel_tilt_angle_tb.sv
module accel_tilt_angle_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atilt_pkg::*;

  localparam int STEPS       = 16;
  localparam int LATENCY     = 34 + STEPS;
  localparam int IDLE_PCT    = 14;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 160;

  localparam logic [1:0] MODE_Z     = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [31:0] MODE_MASK   = 32'h3;
  localparam logic [31:0] GAIN_MASK   = 32'hFFFF;
  localparam logic [31:0] OFFSET_MASK = 32'h1FFFF;

  // atan(2^-i) in 2^-16 degree
  localparam int ATAN_STEP [32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  in_payload_t  in_data = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  out_payload_t out_data;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic         cfg_pready;

  // shadow of the block's registers
  logic [1:0]         mode_r = 2'd1;
  logic [15:0]        gain_r = 16'd18514;
  logic signed [16:0] offset_r = '0;

  out_payload_t angle_q [$];
  logic calm = 1'b0;
  int   err_count = 0;
  int   n_sent = 0;
  int   n_checked = 0;
  int   n_clipped = 0;
  int   n_zero = 0;
  int   n_writes = 0;

  accel_tilt_angle #(.CORDIC_STEPS(STEPS)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("accel_tilt_angle_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // hypotenuse with 8 fractional bits
  function automatic longint root_q8(longint a, longint b);
    longint unsigned s;
    s = longint'(a * a + b * b);
    return longint'(int_sqrt(s << 16));
  endfunction

  // atan2 in 2^-16 degree, vectoring CORDIC
  function automatic longint cordic_atan2(longint num, longint den);
    longint base, x, y, z, dx, dy;
    int i;
    base = 0;
    z = 0;
    if (num == 0 && den == 0) return 0;
    if (den < 0) begin
      base = (num >= 0) ? longint'(DEG180) : -longint'(DEG180);
      den = -den;
      num = -num;
    end
    x = den;
    y = num;
    for (i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_STEP[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_STEP[i];
      end
    end
    return base + z;
  endfunction

  function automatic out_payload_t tilt_predict(in_payload_t s);
    longint ax, ay, az, ang, d, m, q;
    logic neg, clip;
    out_payload_t r;
    ax = $signed(s.accel_x);
    ay = $signed(s.accel_y);
    az = $signed(s.accel_z);
    case (mode_r)
      MODE_X: ang = cordic_atan2(ax * 256, root_q8(ay, az));
      MODE_Y: ang = -cordic_atan2(ay * 256, root_q8(ax, az));
      default: ang = cordic_atan2(root_q8(ax, ay), az * 256);
    endcase
    d = ang * CENTI * longint'(gain_r) - longint'(offset_r) * (longint'(1) <<< 30);
    neg = d < 0;
    m = neg ? -d : d;
    m = (m + (longint'(1) <<< 29)) >>> 30;
    clip = m > OUT_LIMIT;
    if (clip) m = OUT_LIMIT;
    q = neg ? -m : m;
    r.angle_centideg = q[OUT_W-1:0];
    r.clipped = clip;
    return r;
  endfunction

  function automatic in_payload_t mk(int x, int y, int z);
    in_payload_t s;
    s.accel_x = x[15:0];
    s.accel_y = y[15:0];
    s.accel_z = z[15:0];
    return s;
  endfunction

  function automatic logic [15:0] rand_axis(int kind);
    int t;
    if (kind < 65) return 16'($urandom);
    if (kind < 75) begin
      case ($urandom_range(4))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        3: return 16'hFFFF;
        default: return 16'h0001;
      endcase
    end
    t = int'($urandom_range(6)) - 3;
    return t[15:0];
  endfunction

  function automatic in_payload_t rand_sample();
    in_payload_t s;
    int kind;
    kind = $urandom_range(99);
    if (kind >= 87) begin
      s = '0;
      case ($urandom_range(2))
        0: s.accel_x = 16'($urandom);
        1: s.accel_y = 16'($urandom);
        default: s.accel_z = 16'($urandom);
      endcase
    end else begin
      s.accel_x = rand_axis(kind);
      s.accel_y = rand_axis(kind);
      s.accel_z = rand_axis(kind);
    end
    return s;
  endfunction

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_results
    out_payload_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (angle_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = angle_q.pop_front();
        n_checked++;
        if (out_data.angle_centideg !== want.angle_centideg)
          report_mismatch($sformatf("angle_centideg %0d, expected %0d",
            $signed(out_data.angle_centideg), $signed(want.angle_centideg)));
        if (out_data.clipped !== want.clipped)
          report_mismatch($sformatf("clipped %0b, expected %0b",
            out_data.clipped, want.clipped));
      end
    end
  end

  task automatic send_sample(in_payload_t s);
    out_payload_t want;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = tilt_predict(s);
    angle_q.push_back(want);
    n_sent++;
    if (want.clipped) n_clipped++;
    if (s == '0) n_zero++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic cfg_cycle(logic wr, logic [1:0] idx, logic [31:0] wdata,
                           output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(logic [1:0] idx, logic [31:0] want_val, logic [31:0] mask);
    logic [31:0] rd;
    cfg_cycle(1'b0, idx, '0, rd);
    if ((rd & mask) !== (want_val & mask))
      report_mismatch($sformatf("register %0d reads 0x%0h, expected 0x%0h",
        idx, rd & mask, want_val & mask));
  endtask

  task automatic set_reg(logic [1:0] idx, logic [31:0] value);
    logic [31:0] rd, mask;
    case (idx)
      REG_AXIS_MODE: begin
        mode_r = value[1:0];
        mask = MODE_MASK;
      end
      REG_ANGLE_GAIN: begin
        gain_r = value[15:0];
        mask = GAIN_MASK;
      end
      default: begin
        offset_r = value[16:0];
        mask = OFFSET_MASK;
      end
    endcase
    cfg_cycle(1'b1, idx, value, rd);
    check_reg(idx, value, mask);
    n_writes++;
  endtask

  task automatic test_reset_values();
    send_sample('0);
    send_sample(mk(0, 16384, 0));
    send_sample(mk(0, 0, -32768));
    wait_idle();
    check_reg(REG_AXIS_MODE, 32'd1, MODE_MASK);
    check_reg(REG_ANGLE_GAIN, 32'd18514, GAIN_MASK);
    check_reg(REG_ANGLE_OFFSET, 32'd0, OFFSET_MASK);
  endtask

  task automatic test_axis_modes();
    logic [1:0] modes [4];
    modes = '{MODE_X, MODE_Y, MODE_Z, MODE_SPARE};
    foreach (modes[k]) begin
      wait_idle();
      set_reg(REG_AXIS_MODE, {30'd0, modes[k]});
      send_sample('0);
      send_sample(mk(32767, 32767, 32767));
      send_sample(mk(-32768, -32768, -32768));
      send_sample(mk(-32768, 1, -1));
    end
  endtask

  task automatic test_saturation();
    wait_idle();
    set_reg(REG_AXIS_MODE, {30'd0, MODE_Z});
    set_reg(REG_ANGLE_GAIN, 32'hFFFF);
    set_reg(REG_ANGLE_OFFSET, 32'(-36000));
    send_sample(mk(0, 0, -32768));
    send_sample(mk(1, -1, -32768));
    wait_idle();
    set_reg(REG_ANGLE_GAIN, 32'd0);
    send_sample(mk(12345, -2, 7));
    wait_idle();
    set_reg(REG_ANGLE_GAIN, 32'hFFFF);
    set_reg(REG_ANGLE_OFFSET, 32'h0FFFF);
    set_reg(REG_AXIS_MODE, {30'd0, MODE_Y});
    send_sample(mk(0, 32767, 0));
    wait_idle();
    set_reg(REG_ANGLE_OFFSET, 32'h10000);
    set_reg(REG_AXIS_MODE, {30'd0, MODE_Z});
    send_sample(mk(0, 0, -32768));
  endtask

  task automatic test_random_phases();
    logic [31:0] gain_v, off_v;
    int p, n;
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: gain_v = 32'd18514;
        1: gain_v = 32'hFFFF;
        2: gain_v = 32'd16384;
        3: gain_v = 32'd0;
        4: gain_v = 32'd1;
        default: gain_v = $urandom_range(65535);
      endcase
      case (p)
        0: off_v = 32'd0;
        1: off_v = 32'(-36000);
        2: off_v = 32'd36000;
        3: off_v = 32'(-1);
        4: off_v = $urandom;
        default: off_v = 32'(int'($urandom_range(72000)) - 36000);
      endcase
      set_reg(REG_AXIS_MODE, p % 4);
      set_reg(REG_ANGLE_GAIN, gain_v);
      set_reg(REG_ANGLE_OFFSET, off_v);
      calm = (p == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off until the pipe has fully drained
        if (p == 5 && n == PHASE_ITEMS / 2) wait_idle();
        send_sample(rand_sample());
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_axis_modes();
    test_saturation();
    test_random_phases();
    wait_idle();
    $display("sent %0d samples (%0d all-zero, %0d saturated) over %0d register writes",
      n_sent, n_zero, n_clipped, n_writes);
    $display("compared %0d results in all four axis modes, %0d mismatches",
      n_checked, err_count);
    if (err_count == 0) begin
      $display("accel_tilt_angle_tb OK");
    end else begin
      $display("accel_tilt_angle_tb NOT OK");
    end
    $finish;
  end

endmodule
